[rtl/jddm_pkg.sv]
// ----------------------------------------------------------------------------
// jddm_pkg
// Shared types, constants and scaling functions for the joystick
// differential-drive mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

    // Field and register widths.
    localparam int AXIS_W    = 10;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int BRIDGE_W  = 4;

    // Neutral stick position, reset values of the registers and saturation limits.
    localparam logic [AXIS_W-1:0]  NEUTRAL_AXIS   = 10'd510;
    localparam logic [COUNT_W-1:0] TIMEOUT_RST    = 16'd80;
    localparam logic [AXIS_W-1:0]  DEAD_LOW_RST   = 10'd470;
    localparam logic [AXIS_W-1:0]  DEAD_HIGH_RST  = 10'd550;
    localparam logic [COUNT_W-1:0] SILENCE_MAX    = 16'hFFFF;
    localparam logic [BYTE_W-1:0]  SPEED_MAX      = 8'd255;

    // Reciprocal for d*255/513: floor(d * 66716415 / 2^27) is exact for d <= 513.
    localparam int                 UP_SHIFT  = 27;
    localparam int                 UP_PROD_W = AXIS_W + UP_SHIFT;
    localparam logic [UP_SHIFT-1:0] UP_RECIP = 27'd66716415;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_LOW  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_HIGH = 2'd2;

    // Item kinds carried in tuser.
    localparam logic MODE_PACKET = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Bridge codes: bit0 left fwd, bit1 left rev, bit2 right fwd, bit3 right rev.
    localparam logic [BRIDGE_W-1:0] BRIDGE_STOP    = 4'h0;
    localparam logic [BRIDGE_W-1:0] BRIDGE_FWD     = 4'h5;
    localparam logic [BRIDGE_W-1:0] BRIDGE_REV     = 4'hA;
    localparam logic [BRIDGE_W-1:0] BRIDGE_PIVOT_L = 4'h6;
    localparam logic [BRIDGE_W-1:0] BRIDGE_PIVOT_R = 4'h9;

    // Axis state handed from the link stage to the mixer.
    typedef struct packed {
        logic [AXIS_W-1:0] axis_x;
        logic [AXIS_W-1:0] axis_y;
        logic              button_on;
    } link_item_t;

    // Deadband edges.
    typedef struct packed {
        logic [AXIS_W-1:0] lo;
        logic [AXIS_W-1:0] hi;
    } deadband_t;

    // Mixer result.
    typedef struct packed {
        logic [BYTE_W-1:0]   speed_left;
        logic [BYTE_W-1:0]   speed_right;
        logic [BRIDGE_W-1:0] bridge;
        logic                button_led;
    } mix_result_t;

    // byte*1023/255 = 4*byte + floor(byte/85).
    function automatic logic [AXIS_W-1:0] byte_to_axis(input logic [BYTE_W-1:0] b);
        logic [1:0] extra;
        begin
            if (b == 8'd255) begin
                extra = 2'd3;
            end else if (b >= 8'd170) begin
                extra = 2'd2;
            end else if (b >= 8'd85) begin
                extra = 2'd1;
            end else begin
                extra = 2'd0;
            end
            return {b, 2'b00} + AXIS_W'(extra);
        end
    endfunction

    // (v-510)*255/513, zero at or below neutral.
    function automatic logic [BYTE_W-1:0] scale_up(input logic [AXIS_W-1:0] v);
        logic [AXIS_W-1:0]    d;
        logic [UP_PROD_W-1:0] prod;
        begin
            d    = v - NEUTRAL_AXIS;
            prod = UP_PROD_W'(d) * UP_PROD_W'(UP_RECIP);
            if (v <= NEUTRAL_AXIS) begin
                return '0;
            end
            return prod[UP_SHIFT +: BYTE_W];
        end
    endfunction

    // (510-v)*255/510 reduces to (510-v)/2, zero at or above neutral.
    function automatic logic [BYTE_W-1:0] scale_down(input logic [AXIS_W-1:0] v);
        logic [AXIS_W-1:0] d;
        begin
            d = NEUTRAL_AXIS - v;
            if (v >= NEUTRAL_AXIS) begin
                return '0;
            end
            return d[BYTE_W:1];
        end
    endfunction

endpackage

[rtl/jddm_link.sv]
// ----------------------------------------------------------------------------
// jddm_link
// Input stage: takes packets and millisecond ticks, keeps the axis and
// button state and the link-silence counter, and applies the failsafe.
// ----------------------------------------------------------------------------
module jddm_link (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_mode,
    input  logic [jddm_pkg::BYTE_W-1:0]          in_joy_x,
    input  logic [jddm_pkg::BYTE_W-1:0]          in_joy_y,
    input  logic [jddm_pkg::BYTE_W-1:0]          in_button,
    input  logic [jddm_pkg::COUNT_W-1:0]         timeout_ms,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output jddm_pkg::link_item_t                 out_item
);

    logic                                 valid_reg, valid_next;
    logic [jddm_pkg::AXIS_W-1:0]          axis_x_reg, axis_x_next;
    logic [jddm_pkg::AXIS_W-1:0]          axis_y_reg, axis_y_next;
    logic [jddm_pkg::BYTE_W-1:0]          button_reg, button_next;
    logic [jddm_pkg::COUNT_W-1:0]         silence_reg, silence_next;
    logic                                 accept;

    // The stage frees up whenever the mixer takes its item.
    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Next link state for the item being taken.
    always_comb begin
        axis_x_next  = axis_x_reg;
        axis_y_next  = axis_y_reg;
        button_next  = button_reg;
        silence_next = silence_reg;
        valid_next   = in_ready ? in_valid : valid_reg;
        if (accept) begin
            if (in_mode == jddm_pkg::MODE_PACKET) begin
                axis_x_next  = jddm_pkg::byte_to_axis(in_joy_x);
                axis_y_next  = jddm_pkg::byte_to_axis(in_joy_y);
                button_next  = in_button;
                silence_next = '0;
            end else begin
                if (silence_reg != jddm_pkg::SILENCE_MAX) begin
                    silence_next = silence_reg + 1'b1;
                end
                if (silence_next >= timeout_ms) begin
                    axis_x_next = jddm_pkg::NEUTRAL_AXIS;
                    axis_y_next = jddm_pkg::NEUTRAL_AXIS;
                    button_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            axis_x_reg  <= jddm_pkg::NEUTRAL_AXIS;
            axis_y_reg  <= jddm_pkg::NEUTRAL_AXIS;
            button_reg  <= '0;
            silence_reg <= '0;
        end else begin
            valid_reg   <= valid_next;
            axis_x_reg  <= axis_x_next;
            axis_y_reg  <= axis_y_next;
            button_reg  <= button_next;
            silence_reg <= silence_next;
        end
    end

    assign out_valid          = valid_reg;
    assign out_item.axis_x    = axis_x_reg;
    assign out_item.axis_y    = axis_y_reg;
    assign out_item.button_on = (button_reg == 8'd1);

    // The silence counter only clears or steps up by one.
    a_silence_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (silence_reg != $past(silence_reg)) |->
            (silence_reg == '0 || silence_reg == $past(silence_reg) + 1'b1))
        else $error("silence counter jumped");

    // A packet clears the silence counter.
    a_packet_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_mode == jddm_pkg::MODE_PACKET) |=> (silence_reg == '0))
        else $error("packet did not clear silence counter");

endmodule

[rtl/jddm_mix.sv]
// ----------------------------------------------------------------------------
// jddm_mix
// Mixer stage: turns the axis state into two PWM speeds and four bridge
// bits, keeping the previous values where no branch applies.
// ----------------------------------------------------------------------------
module jddm_mix (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  jddm_pkg::link_item_t  in_item,
    input  jddm_pkg::deadband_t   deadband,
    output logic                  out_valid,
    input  logic                  out_ready,
    output jddm_pkg::mix_result_t out_result
);

    logic                              valid_reg;
    logic [jddm_pkg::BYTE_W-1:0]       left_reg, left_next;
    logic [jddm_pkg::BYTE_W-1:0]       right_reg, right_next;
    logic [jddm_pkg::BRIDGE_W-1:0]     bridge_reg, bridge_next;
    logic                              button_led_reg;
    logic                              accept;
    logic [jddm_pkg::BYTE_W-1:0]       up_x, up_y, down_x, down_y;
    logic                              y_mid, x_mid;
    logic                              x_low, x_high, y_low, y_high;
    logic [jddm_pkg::BYTE_W:0]         sum;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Mapped magnitudes of both axes.
    assign up_x   = jddm_pkg::scale_up(in_item.axis_x);
    assign up_y   = jddm_pkg::scale_up(in_item.axis_y);
    assign down_x = jddm_pkg::scale_down(in_item.axis_x);
    assign down_y = jddm_pkg::scale_down(in_item.axis_y);

    assign x_low  = in_item.axis_x < deadband.lo;
    assign x_high = in_item.axis_x > deadband.hi;
    assign y_low  = in_item.axis_y < deadband.lo;
    assign y_high = in_item.axis_y > deadband.hi;
    assign y_mid  = (in_item.axis_y > deadband.lo) && (in_item.axis_y < deadband.hi);
    assign x_mid  = (in_item.axis_x > deadband.lo) && (in_item.axis_x < deadband.hi);

    // Branches in priority order; later ones override earlier ones.
    always_comb begin
        left_next   = left_reg;
        right_next  = right_reg;
        bridge_next = bridge_reg;
        sum         = '0;
        if (y_high) begin
            bridge_next = jddm_pkg::BRIDGE_FWD;
            left_next   = up_y;
            right_next  = up_y;
        end
        if (y_low) begin
            bridge_next = jddm_pkg::BRIDGE_REV;
            left_next   = down_y;
            right_next  = down_y;
        end
        if (y_mid && x_low) begin
            bridge_next = jddm_pkg::BRIDGE_PIVOT_L;
            left_next   = down_x;
            right_next  = down_x;
        end else if (x_low) begin
            // Blended left turn.
            left_next  = (left_next > down_x) ? left_next - down_x : '0;
            sum        = {1'b0, right_next} + {1'b0, down_x};
            right_next = sum[jddm_pkg::BYTE_W] ? jddm_pkg::SPEED_MAX
                                               : sum[jddm_pkg::BYTE_W-1:0];
        end
        if (y_mid && x_high) begin
            bridge_next = jddm_pkg::BRIDGE_PIVOT_R;
            left_next   = up_x;
            right_next  = up_x;
        end else if (x_high) begin
            // Blended right turn.
            sum        = {1'b0, left_next} + {1'b0, up_x};
            left_next  = sum[jddm_pkg::BYTE_W] ? jddm_pkg::SPEED_MAX
                                               : sum[jddm_pkg::BYTE_W-1:0];
            right_next = (right_next > up_x) ? right_next - up_x : '0;
        end
        if (y_mid && x_mid) begin
            left_next   = '0;
            right_next  = '0;
            bridge_next = jddm_pkg::BRIDGE_STOP;
        end
    end

    // Drive state doubles as the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            left_reg       <= '0;
            right_reg      <= '0;
            bridge_reg     <= jddm_pkg::BRIDGE_STOP;
            button_led_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (accept) begin
                left_reg       <= left_next;
                right_reg      <= right_next;
                bridge_reg     <= bridge_next;
                button_led_reg <= in_item.button_on;
            end
        end
    end

    assign out_valid              = valid_reg;
    assign out_result.speed_left  = left_reg;
    assign out_result.speed_right = right_reg;
    assign out_result.bridge      = bridge_reg;
    assign out_result.button_led  = button_led_reg;

    // A bridge side is never driven forward and reverse at once.
    a_bridge_sides: assert property (@(posedge aclk) disable iff (!aresetn)
        !(bridge_reg[0] && bridge_reg[1]) && !(bridge_reg[2] && bridge_reg[3]))
        else $error("bridge shoot-through code");

    // A result only appears after an item was waiting at the input.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(valid_reg) |-> $past(in_valid))
        else $error("result without input item");

endmodule

[rtl/joystick_differential_drive_mixer.sv]
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer
// Each input item is registered in the link stage, then its result in the mixer
// stage. Throughput: one item per cycle while m_tready is high; each stage holds
// one item, and the speed recurrence closes within the mixer stage.
// Reset (aresetn low, synchronous) returns the axes to neutral, clears the
// button, silence counter, speeds and bridge bits and loads register defaults.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [jddm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [jddm_pkg::CFG_W-1:0]          cfg_wdata,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,  // joy_x, joy_y, button
    input  logic                                s_tuser,  // mode
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // speed_left, speed_right, left_fwd, left_rev, right_fwd, right_rev,
    // button_led, drive_led, zero padding
    output logic [23:0]                         m_tdata
);

    logic [jddm_pkg::COUNT_W-1:0] timeout_reg;
    jddm_pkg::deadband_t          deadband_reg;
    logic                         link_valid;
    logic                         link_ready;
    jddm_pkg::link_item_t         link_item;
    jddm_pkg::mix_result_t        result;
    logic                         drive_led;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg     <= jddm_pkg::TIMEOUT_RST;
            deadband_reg.lo <= jddm_pkg::DEAD_LOW_RST;
            deadband_reg.hi <= jddm_pkg::DEAD_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                jddm_pkg::REG_TIMEOUT:   timeout_reg     <= cfg_wdata;
                jddm_pkg::REG_DEAD_LOW:  deadband_reg.lo <= cfg_wdata[jddm_pkg::AXIS_W-1:0];
                jddm_pkg::REG_DEAD_HIGH: deadband_reg.hi <= cfg_wdata[jddm_pkg::AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    jddm_link u_link (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_joy_x   (s_tdata[7:0]),
        .in_joy_y   (s_tdata[15:8]),
        .in_button  (s_tdata[23:16]),
        .timeout_ms (timeout_reg),
        .out_valid  (link_valid),
        .out_ready  (link_ready),
        .out_item   (link_item)
    );

    jddm_mix u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (link_valid),
        .in_ready   (link_ready),
        .in_item    (link_item),
        .deadband   (deadband_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the result item.
    assign drive_led = (result.speed_left != '0) || (result.speed_right != '0);
    assign m_tdata   = {2'b00, drive_led, result.button_led, result.bridge,
                        result.speed_right, result.speed_left};

endmodule

[verif/drive_mix_checker.sv]
// ----------------------------------------------------------------------------
// drive_mix_checker
// Watches the configuration port and both item channels of the joystick
// differential-drive mixer. Every accepted input item is run through a local
// model of the link failsafe and the motor mixing, and the predicted drive
// item is queued. Every accepted result item is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module drive_mix_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [jddm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [jddm_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [23:0]                     s_tdata,  // joy_x, joy_y, button
    input  logic                            s_tuser,  // mode
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // speed_left, speed_right, left_fwd, left_rev, right_fwd, right_rev,
    // button_led, drive_led, zero padding
    input  logic [23:0]                     m_tdata,
    output int                              mismatch_total,
    output int                              results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [jddm_pkg::BYTE_W-1:0] speed_left;
        logic [jddm_pkg::BYTE_W-1:0] speed_right;
        logic                        left_fwd;
        logic                        left_rev;
        logic                        right_fwd;
        logic                        right_rev;
        logic                        button_led;
        logic                        drive_led;
    } drive_out_t;

    localparam int CENTER   = int'(jddm_pkg::NEUTRAL_AXIS);
    localparam int DUTY_TOP = int'(jddm_pkg::SPEED_MAX);

    // Local copy of the registers.
    logic [jddm_pkg::CFG_W-1:0]    fallback_ms;
    logic [jddm_pkg::AXIS_W-1:0]   band_lo;
    logic [jddm_pkg::AXIS_W-1:0]   band_hi;

    // Local copy of the link and mixer state.
    logic [jddm_pkg::AXIS_W-1:0]   pos_x;
    logic [jddm_pkg::AXIS_W-1:0]   pos_y;
    logic [jddm_pkg::BYTE_W-1:0]   held_button;
    logic [jddm_pkg::COUNT_W-1:0]  quiet_ms;
    int                            left_duty;
    int                            right_duty;
    logic [jddm_pkg::BRIDGE_W-1:0] bridge_now;

    drive_out_t          due_drives[$];

    // Stick byte to 0..1023, truncating.
    function automatic int stick_to_axis(input logic [jddm_pkg::BYTE_W-1:0] b);
        return (int'(b) * 1023) / 255;
    endfunction

    // Duty for an axis above center; nothing at or below it.
    function automatic int forward_duty(input int v);
        if (v <= CENTER) begin
            return 0;
        end
        return ((v - CENTER) * 255) / 513;
    endfunction

    // Duty for an axis below center; nothing at or above it.
    function automatic int reverse_duty(input int v);
        if (v >= CENTER) begin
            return 0;
        end
        return ((CENTER - v) * 255) / 510;
    endfunction

    // Applies one item to the local state and returns the drive it produces.
    function automatic drive_out_t mix_item(input logic kind, input logic [23:0] payload);
        int         x;
        int         y;
        int         lo;
        int         hi;
        int         m;
        bit         y_mid;
        bit         x_mid;
        drive_out_t r;

        if (kind == jddm_pkg::MODE_PACKET) begin
            pos_x       = (jddm_pkg::AXIS_W)'(stick_to_axis(payload[7:0]));
            pos_y       = (jddm_pkg::AXIS_W)'(stick_to_axis(payload[15:8]));
            held_button = payload[23:16];
            quiet_ms    = '0;
        end else begin
            if (quiet_ms != jddm_pkg::SILENCE_MAX) begin
                quiet_ms = quiet_ms + 1'b1;
            end
            // Link lost: fall back to a centered stick and a released button.
            if (quiet_ms >= fallback_ms) begin
                pos_x       = jddm_pkg::NEUTRAL_AXIS;
                pos_y       = jddm_pkg::NEUTRAL_AXIS;
                held_button = '0;
            end
        end

        x     = int'(pos_x);
        y     = int'(pos_y);
        lo    = int'(band_lo);
        hi    = int'(band_hi);
        y_mid = (y > lo) && (y < hi);
        x_mid = (x > lo) && (x < hi);

        // Branches are taken in order; a later one overrides an earlier one.
        if (y > hi) begin
            bridge_now = jddm_pkg::BRIDGE_FWD;
            left_duty  = forward_duty(y);
            right_duty = left_duty;
        end
        if (y < lo) begin
            bridge_now = jddm_pkg::BRIDGE_REV;
            left_duty  = reverse_duty(y);
            right_duty = left_duty;
        end
        if (y_mid && x < lo) begin
            bridge_now = jddm_pkg::BRIDGE_PIVOT_L;
            left_duty  = reverse_duty(x);
            right_duty = left_duty;
        end else if (x < lo) begin
            m          = reverse_duty(x);
            left_duty  = (left_duty > m) ? left_duty - m : 0;
            right_duty = (right_duty + m > DUTY_TOP) ? DUTY_TOP : right_duty + m;
        end
        if (y_mid && x > hi) begin
            bridge_now = jddm_pkg::BRIDGE_PIVOT_R;
            left_duty  = forward_duty(x);
            right_duty = left_duty;
        end else if (x > hi) begin
            m          = forward_duty(x);
            left_duty  = (left_duty + m > DUTY_TOP) ? DUTY_TOP : left_duty + m;
            right_duty = (right_duty > m) ? right_duty - m : 0;
        end
        if (y_mid && x_mid) begin
            left_duty  = 0;
            right_duty = 0;
            bridge_now = jddm_pkg::BRIDGE_STOP;
        end

        r.speed_left  = (jddm_pkg::BYTE_W)'(left_duty);
        r.speed_right = (jddm_pkg::BYTE_W)'(right_duty);
        r.left_fwd    = bridge_now[0];
        r.left_rev    = bridge_now[1];
        r.right_fwd   = bridge_now[2];
        r.right_rev   = bridge_now[3];
        r.button_led  = (held_button == 8'd1);
        r.drive_led   = (left_duty > 0) || (right_duty > 0);
        return r;
    endfunction

    // Reports one field that differs and returns 1 for it.
    function automatic int field_check(input string label, input int want, input int got);
        if (want == got) begin
            return 0;
        end
        $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
        return 1;
    endfunction

    // Everything is sampled at the rising edge, where handshakes complete.
    always @(posedge aclk) begin : watch_edges
        drive_out_t want;
        drive_out_t got;
        int         bad;

        if (!aresetn) begin
            fallback_ms    = jddm_pkg::TIMEOUT_RST;
            band_lo        = jddm_pkg::DEAD_LOW_RST;
            band_hi        = jddm_pkg::DEAD_HIGH_RST;
            pos_x          = jddm_pkg::NEUTRAL_AXIS;
            pos_y          = jddm_pkg::NEUTRAL_AXIS;
            held_button    = '0;
            quiet_ms       = '0;
            left_duty      = 0;
            right_duty     = 0;
            bridge_now     = jddm_pkg::BRIDGE_STOP;
            mismatch_total = 0;
            due_drives.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    jddm_pkg::REG_TIMEOUT: begin
                        fallback_ms = cfg_wdata;
                    end
                    jddm_pkg::REG_DEAD_LOW: begin
                        band_lo = cfg_wdata[jddm_pkg::AXIS_W-1:0];
                    end
                    jddm_pkg::REG_DEAD_HIGH: begin
                        band_hi = cfg_wdata[jddm_pkg::AXIS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (s_tvalid && s_tready) begin
                due_drives.push_back(mix_item(s_tuser, s_tdata));
            end

            if (m_tvalid && m_tready) begin
                got.speed_left  = m_tdata[7:0];
                got.speed_right = m_tdata[15:8];
                got.left_fwd    = m_tdata[16];
                got.left_rev    = m_tdata[17];
                got.right_fwd   = m_tdata[18];
                got.right_rev   = m_tdata[19];
                got.button_led  = m_tdata[20];
                got.drive_led   = m_tdata[21];
                if (due_drives.size() == 0) begin
                    $display("%0t: result item with none expected, expected nothing, actual %h",
                             $time, m_tdata);
                    mismatch_total++;
                end else begin
                    want = due_drives.pop_front();
                    bad  = field_check("speed_left", want.speed_left, got.speed_left)
                         + field_check("speed_right", want.speed_right, got.speed_right)
                         + field_check("left_fwd", want.left_fwd, got.left_fwd)
                         + field_check("left_rev", want.left_rev, got.left_rev)
                         + field_check("right_fwd", want.right_fwd, got.right_fwd)
                         + field_check("right_rev", want.right_rev, got.right_rev)
                         + field_check("button_led", want.button_led, got.button_led)
                         + field_check("drive_led", want.drive_led, got.drive_led);
                    if (bad != 0) begin
                        mismatch_total++;
                    end
                end
            end
        end
        results_due = due_drives.size();
    end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives joystick packets and millisecond ticks into the differential-drive
// mixer under several register settings: a directed part for every drive
// branch, deadband edges, crossed and extreme deadbands and the link-loss
// failsafe, then random packets and tick runs with random idling on both
// channels and one long result back-pressure. Checking is done beside the
// block by drive_mix_checker.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 120;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 550;
    localparam int RANDOM_PHASES = 8;
    // Index past the last register; writes to it must change nothing.
    localparam logic [jddm_pkg::CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [jddm_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [jddm_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [23:0]                     s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [23:0]                     m_tdata;

    int                    mismatch_total;
    int                    results_due;
    int                    cycle_count = 0;
    bit                    idling_on   = 1'b1;
    int                    hold_asks   = 0;
    int                    hold_taken  = 0;
    int                    hold_left   = 0;
    int                    sink_gap    = 0;
    int                    cur_timeout = int'(jddm_pkg::TIMEOUT_RST);

    always #4ns aclk = ~aclk;

    joystick_differential_drive_mixer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    drive_mix_checker mix_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_total (mismatch_total),
        .results_due    (results_due)
    );

    // Run-away guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: one long hold when asked, otherwise random stall bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asks) begin
            hold_taken <= hold_asks;
            hold_left  <= LONG_HOLD - 1;
            m_tready   <= 1'b0;
        end else if (sink_gap != 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            sink_gap <= $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offers one item, sometimes after an idle burst, and waits for its acceptance.
    task automatic push_item(input logic kind, input logic [7:0] jx, input logic [7:0] jy,
                             input logic [7:0] btn);
        int gap;
        gap = (idling_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {btn, jy, jx};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task automatic push_packet(input logic [7:0] jx, input logic [7:0] jy,
                               input logic [7:0] btn);
        push_item(jddm_pkg::MODE_PACKET, jx, jy, btn);
    endtask

    // The data bytes of a tick are noise that the block must ignore.
    task automatic push_tick();
        push_item(jddm_pkg::MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Stops offering and waits until every expected result has come out.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [jddm_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [jddm_pkg::CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == jddm_pkg::REG_TIMEOUT) begin
            cur_timeout = int'(value);
        end
    endtask

    // Deadband edges; the unused upper data bits carry noise.
    task automatic set_band(input logic [jddm_pkg::AXIS_W-1:0] lo,
                            input logic [jddm_pkg::AXIS_W-1:0] hi);
        write_reg(jddm_pkg::REG_DEAD_LOW, {6'($urandom), lo});
        write_reg(jddm_pkg::REG_DEAD_HIGH, {6'($urandom), hi});
    endtask

    // Mostly realistic settings, sometimes extreme or crossed.
    task automatic random_config();
        logic [jddm_pkg::CFG_W-1:0] t;
        case ($urandom_range(0, 5))
            0: begin
                t = '0;
            end
            1: begin
                t = jddm_pkg::SILENCE_MAX;
            end
            2, 3: begin
                t = (jddm_pkg::CFG_W)'($urandom_range(1, 12));
            end
            4: begin
                t = (jddm_pkg::CFG_W)'($urandom_range(13, 60));
            end
            default: begin
                t = (jddm_pkg::CFG_W)'($urandom_range(1, 65535));
            end
        endcase
        write_reg(jddm_pkg::REG_TIMEOUT, t);
        case ($urandom_range(0, 4))
            0, 1, 2: begin
                // Edges that a stick byte can land on exactly.
                set_band((jddm_pkg::AXIS_W)'(($urandom_range(105, 125) * 1023) / 255),
                         (jddm_pkg::AXIS_W)'(($urandom_range(130, 150) * 1023) / 255));
            end
            3: begin
                set_band((jddm_pkg::AXIS_W)'($urandom_range(0, 1023)),
                         (jddm_pkg::AXIS_W)'($urandom_range(0, 1023)));
            end
            default: begin
                set_band((jddm_pkg::AXIS_W)'($urandom_range(440, 509)),
                         (jddm_pkg::AXIS_W)'($urandom_range(511, 600)));
            end
        endcase
    endtask

    // Stick bytes weighted toward the deadband and the ends of travel.
    function automatic logic [7:0] pick_stick();
        case ($urandom_range(0, 4))
            0: begin
                return 8'($urandom_range(110, 145));
            end
            1: begin
                return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    initial begin : stimulus
        int sent;
        int burst;
        int span;
        int ph;
        int i;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: every drive branch and the button LED.
        push_packet(8'd128, 8'd128, 8'd0);
        push_packet(8'd128, 8'd255, 8'd1);
        push_packet(8'd128, 8'd0, 8'd255);
        push_packet(8'd0, 8'd128, 8'd2);
        push_packet(8'd255, 8'd128, 8'd0);
        push_packet(8'd0, 8'd255, 8'd1);
        push_packet(8'd255, 8'd0, 8'd0);
        push_packet(8'd230, 8'd200, 8'd1);
        push_tick();
        push_tick();

        // Edges a stick byte can reach; an axis on an edge keeps the last drive.
        settle();
        write_reg(jddm_pkg::REG_TIMEOUT, 16'd3);
        set_band(10'd473, 10'd549);
        write_reg(REG_SPARE, 16'($urandom));
        push_packet(8'd255, 8'd255, 8'd1);
        push_packet(8'd118, 8'd128, 8'd1);
        push_packet(8'd128, 8'd137, 8'd0);
        push_packet(8'd0, 8'd118, 8'd1);
        for (i = 0; i < 3; i++) begin
            push_tick();
        end

        // Crossed deadband, and a zero timeout that trips on every tick.
        settle();
        write_reg(jddm_pkg::REG_TIMEOUT, 16'd0);
        set_band(10'd600, 10'd400);
        push_packet(8'd160, 8'd100, 8'd1);
        push_packet(8'd255, 8'd255, 8'd0);
        push_tick();

        // Widest deadband: no axis can get past either edge.
        settle();
        write_reg(jddm_pkg::REG_TIMEOUT, 16'd1);
        set_band(10'd0, 10'd1023);
        push_packet(8'd0, 8'd0, 8'd1);
        push_packet(8'd255, 8'd255, 8'd1);
        push_tick();

        // Fully inverted deadband with the longest timeout.
        settle();
        write_reg(jddm_pkg::REG_TIMEOUT, jddm_pkg::SILENCE_MAX);
        set_band(10'd1023, 10'd0);
        push_packet(8'd255, 8'd0, 8'd1);
        push_packet(8'd128, 8'd128, 8'd0);
        push_tick();

        // Random phases: packets and tick runs, long enough to trip the failsafe when the timeout is 24 or less.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            random_config();
            if (ph == RANDOM_PHASES - 1) begin
                idling_on = 1'b0;
            end
            if (ph == 1) begin
                hold_asks++;
            end
            sent = 0;
            while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
                if ($urandom_range(0, 9) < 6) begin
                    push_packet(pick_stick(), pick_stick(),
                                $urandom_range(0, 3) == 0 ? 8'd1 : 8'($urandom));
                    sent++;
                end else begin
                    span  = (cur_timeout <= 24) ? cur_timeout + 2 : 8;
                    burst = $urandom_range(1, span);
                    for (i = 0; i < burst; i++) begin
                        push_tick();
                    end
                    sent += burst;
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_total == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
